// ===== sv/vbce_pkg.sv =====
// ----------------------------------------------------------------------------
// vbce_pkg: shared constants and helpers of the voxel box collision engine
// Grid geometry, field widths, request modes, register indexes and the
// cell address function.
// ----------------------------------------------------------------------------
package vbce_pkg;

   // grid geometry
   localparam int GRID_X      = 64;
   localparam int GRID_Z      = 64;
   localparam int LOW_Y       = 0;
   localparam int HIGH_Y      = 63;
   localparam int GROUND_SCAN = 10;
   localparam int FRAC_BITS   = 8;

   // field widths
   localparam int MODE_W  = 2;
   localparam int COORD_W = 16;
   localparam int CELL_W  = 6;
   localparam int ID_W    = 8;
   localparam int SIZE_W  = 10;
   localparam int TOL_W   = 8;

   // derived widths
   localparam int D_W        = COORD_W + 2;                 // doubled coordinates
   localparam int BND_W      = D_W - FRAC_BITS + 2;         // cell bounds, signed
   localparam int XW         = $clog2(GRID_X);
   localparam int ZW         = $clog2(GRID_Z);
   localparam int YW         = $clog2(HIGH_Y + 1);
   localparam int STORE_SIZE = GRID_X * GRID_Z * (HIGH_Y - LOW_Y + 1);
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int G_W        = $clog2(HIGH_Y + 2) + FRAC_BITS + 8;
   localparam int NO_GROUND_Q = (LOW_Y - 100) * (1 << FRAC_BITS);

   // request modes
   localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COLLIDE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GROUND  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CELL    = 2'd3;

   // register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_WATER   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_WATER    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUND_TOL    = 3'd4;

   localparam logic [SIZE_W-1:0] RST_PLAYER_WIDTH  = 10'd154;
   localparam logic [SIZE_W-1:0] RST_PLAYER_HEIGHT = 10'd461;
   localparam logic [ID_W-1:0]   RST_STILL_WATER   = 8'd8;
   localparam logic [ID_W-1:0]   RST_FLOW_WATER    = 8'd9;
   localparam logic [TOL_W-1:0]  RST_GROUND_TOL    = 8'd2;

   // linear store address: layer-major, then z, then x
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [XW-1:0] x,
                                                   input logic [YW-1:0] y,
                                                   input logic [ZW-1:0] z);
      logic [ADDR_W-1:0] row;
      row = ADDR_W'(y) * ADDR_W'(GRID_Z) + ADDR_W'(z);
      return row * ADDR_W'(GRID_X) + ADDR_W'(x);
   endfunction

endpackage

// ===== sv/vbce_if.sv =====
// ----------------------------------------------------------------------------
// vbce_if: channel interfaces of the voxel box collision engine
// Request, response and register-write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface vbce_req_if;
   logic                                valid;
   logic                                ready;
   logic [vbce_pkg::MODE_W-1:0]         mode;
   logic signed [vbce_pkg::COORD_W-1:0] pos_x;
   logic signed [vbce_pkg::COORD_W-1:0] pos_y;
   logic signed [vbce_pkg::COORD_W-1:0] pos_z;
   logic signed [vbce_pkg::COORD_W-1:0] move_x;
   logic signed [vbce_pkg::COORD_W-1:0] move_y;
   logic signed [vbce_pkg::COORD_W-1:0] move_z;
   logic [vbce_pkg::CELL_W-1:0]         cell_x;
   logic [vbce_pkg::CELL_W-1:0]         cell_y;
   logic [vbce_pkg::CELL_W-1:0]         cell_z;
   logic [vbce_pkg::ID_W-1:0]           cell_id;

   modport source (output valid, mode, pos_x, pos_y, pos_z, move_x, move_y, move_z,
                   cell_x, cell_y, cell_z, cell_id, input ready);
   modport sink   (input valid, mode, pos_x, pos_y, pos_z, move_x, move_y, move_z,
                   cell_x, cell_y, cell_z, cell_id, output ready);
endinterface

interface vbce_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                collides;
   logic signed [vbce_pkg::COORD_W-1:0] ground_height;
   logic                                on_ground;

   modport source (output valid, collides, ground_height, on_ground, input ready);
   modport sink   (input valid, collides, ground_height, on_ground, output ready);
endinterface

interface vbce_csr_if;
   logic                                valid;
   logic                                ready;
   logic [vbce_pkg::CSR_IDX_W-1:0]      index;
   logic [vbce_pkg::CSR_DATA_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== sv/voxel_box_collision_engine_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_box_collision_engine_unit: voxel grid with player box queries
// Holds a grid of block ids and answers write, box collision, ground search
// and single-cell overlap requests with one sequencer, one store write port and one store read port.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | contents
//  req_bus  | in  | valid / ready | mode, pos_x/y/z, move_x/y/z, cell_x/y/z, cell_id
//  rsp_bus  | out | valid / ready | collides, ground_height, on_ground
//  csr_bus  | in  | valid / ready | index, wdata (always ready)
//
//  Write: write step, then finish. Other requests form target and bounds per
//  axis, then collision and ground search read cells one per cycle via the
//  store read port (box footprint times layers; ground search: ten layers).
//  After reset a clearing pass writes air to all 262144 cells, one a cycle;
//  no request is taken meanwhile, register writes are.
//  A finished response waits in the output register; the next request is
//  taken while it waits, and a further result holds until it is taken.
// ----------------------------------------------------------------------------
module voxel_box_collision_engine_unit (
   input logic        clock,
   input logic        reset,
   vbce_req_if.sink   req_bus,
   vbce_rsp_if.source rsp_bus,
   vbce_csr_if.sink   csr_bus
);

   localparam int COORD_W = vbce_pkg::COORD_W;
   localparam int D_W     = vbce_pkg::D_W;
   localparam int BND_W   = vbce_pkg::BND_W;
   localparam int XW      = vbce_pkg::XW;
   localparam int YW      = vbce_pkg::YW;
   localparam int ZW      = vbce_pkg::ZW;
   localparam int ADDR_W  = vbce_pkg::ADDR_W;
   localparam int G_W     = vbce_pkg::G_W;
   localparam int DF_W    = G_W + 1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic signed [BND_W-1:0] B_ZERO  = '0;
   localparam logic signed [BND_W-1:0] B_ONE   = BND_W'(1);
   localparam logic signed [BND_W-1:0] B_SCAN  = BND_W'(vbce_pkg::GROUND_SCAN - 1);
   localparam logic signed [BND_W-1:0] B_X_MAX = BND_W'(vbce_pkg::GRID_X - 1);
   localparam logic signed [BND_W-1:0] B_Z_MAX = BND_W'(vbce_pkg::GRID_Z - 1);
   localparam logic signed [BND_W-1:0] B_Y_MIN = BND_W'(vbce_pkg::LOW_Y);
   localparam logic signed [BND_W-1:0] B_Y_MAX = BND_W'(vbce_pkg::HIGH_Y);

   localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [G_W-1:0]     G_MAX = G_W'(C_MAX);
   localparam logic signed [G_W-1:0]     G_MIN = G_W'(C_MIN);
   localparam logic signed [G_W-1:0]     G_NONE = G_W'(vbce_pkg::NO_GROUND_Q);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_WRITE = 8'b0000_0100,
      S_TGT   = 8'b0000_1000,
      S_BND   = 8'b0001_0000,
      S_INIT  = 8'b0010_0000,
      S_SCAN  = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } state_type;

   // control
   state_type          state_ff, state_in;
   logic [1:0]         axis_ff, axis_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               issue_done_ff, issue_done_in;
   logic               rd_valid_ff, rd_valid_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [vbce_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [vbce_pkg::SIZE_W-1:0] height_ff, height_in;
   logic [vbce_pkg::ID_W-1:0]   still_ff, still_in;
   logic [vbce_pkg::ID_W-1:0]   flow_ff, flow_in;
   logic [vbce_pkg::TOL_W-1:0]  tol_ff, tol_in;

   // request
   logic [vbce_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic signed [COORD_W-1:0]    pos_ff [3];
   logic signed [COORD_W-1:0]    pos_in [3];
   logic signed [COORD_W-1:0]    move_ff [3];
   logic signed [COORD_W-1:0]    move_in [3];
   logic [vbce_pkg::CELL_W-1:0]  cell_x_ff, cell_x_in;
   logic [vbce_pkg::CELL_W-1:0]  cell_y_ff, cell_y_in;
   logic [vbce_pkg::CELL_W-1:0]  cell_z_ff, cell_z_in;
   logic [vbce_pkg::ID_W-1:0]    cell_id_ff, cell_id_in;

   // per-axis target and cell bounds
   logic signed [COORD_W-1:0] t_ff [3];
   logic signed [COORD_W-1:0] t_in [3];
   logic signed [BND_W-1:0]   lo_ff [3];
   logic signed [BND_W-1:0]   lo_in [3];
   logic signed [BND_W-1:0]   hi_ff [3];
   logic signed [BND_W-1:0]   hi_in [3];

   // scan
   logic [XW-1:0] xlo_c_ff, xlo_c_in, xhi_c_ff, xhi_c_in, xs_ff, xs_in;
   logic [ZW-1:0] zlo_c_ff, zlo_c_in, zhi_c_ff, zhi_c_in, zs_ff, zs_in;
   logic [YW-1:0] ylo_c_ff, ylo_c_in, ys_ff, ys_in;
   logic [YW-1:0] rd_y_ff, rd_y_in;
   logic [YW-1:0] hit_y_ff, hit_y_in;

   // response
   logic                      rsp_collides_ff, rsp_collides_in;
   logic signed [COORD_W-1:0] rsp_height_ff, rsp_height_in;
   logic                      rsp_on_ground_ff, rsp_on_ground_in;

   // store
   logic [vbce_pkg::ID_W-1:0] store_mem [vbce_pkg::STORE_SIZE];
   logic [vbce_pkg::ID_W-1:0] rd_data_ff;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [ADDR_W-1:0]         mem_raddr;
   logic [vbce_pkg::ID_W-1:0] mem_wdata;

   // shared datapath
   logic                      req_accept;
   logic signed [COORD_W-1:0] p_sel, m_sel, t_sel, t_sat;
   logic signed [COORD_W:0]   tgt_sum;
   logic signed [D_W-1:0]     t2, lo_off, hi_off, lo2, hi2;
   logic                      strict;
   logic signed [BND_W-1:0]   lo_b, hi_b, start_b;
   logic signed [BND_W-1:0]   xe_lo, xe_hi, ye_lo, ye_hi, ze_lo, ze_hi;
   logic signed [BND_W-1:0]   cx_b, cy_b, cz_b;
   logic                      rd_solid, scan_last, in_grid;
   logic signed [G_W-1:0]     g_val;
   logic signed [DF_W-1:0]    diff, tol_s;
   logic signed [COORD_W-1:0] g_sat;
   logic                      g_on;

   assign req_accept    = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.collides      = rsp_collides_ff;
   assign rsp_bus.ground_height = rsp_height_ff;
   assign rsp_bus.on_ground     = rsp_on_ground_ff;

   // target: pos, plus move when colliding, saturated, one axis a cycle
   always_comb begin
      p_sel   = pos_ff[axis_ff];
      m_sel   = (mode_ff == vbce_pkg::MODE_COLLIDE) ? move_ff[axis_ff] : '0;
      tgt_sum = {p_sel[COORD_W-1], p_sel} + {m_sel[COORD_W-1], m_sel};
      if (tgt_sum[COORD_W] != tgt_sum[COORD_W-1]) begin
         t_sat = tgt_sum[COORD_W] ? C_MIN : C_MAX;
      end else begin
         t_sat = tgt_sum[COORD_W-1:0];
      end
   end

   // cell bounds in doubled units: lo = floor(lo2), hi = floor(hi2 - strict)
   always_comb begin
      t_sel  = t_ff[axis_ff];
      t2     = {{(D_W-COORD_W-1){t_sel[COORD_W-1]}}, t_sel, 1'b0};
      strict = (mode_ff != vbce_pkg::MODE_GROUND);
      if (axis_ff == AXIS_Y) begin
         lo_off = '0;
         hi_off = D_W'({height_ff, 1'b0});
      end else begin
         lo_off = D_W'(width_ff);
         hi_off = D_W'(width_ff);
      end
      lo2     = t2 - lo_off;
      hi2     = t2 + hi_off - D_W'(strict);
      lo_b    = BND_W'(lo2 >>> (vbce_pkg::FRAC_BITS + 1));
      hi_b    = BND_W'(hi2 >>> (vbce_pkg::FRAC_BITS + 1));
      start_b = BND_W'(pos_ff[AXIS_Y] >>> vbce_pkg::FRAC_BITS) - B_ONE;
   end

   // clamp to the grid, and the single-cell geometry test
   always_comb begin
      xe_lo = (lo_ff[AXIS_X] < B_ZERO)  ? B_ZERO  : lo_ff[AXIS_X];
      xe_hi = (hi_ff[AXIS_X] > B_X_MAX) ? B_X_MAX : hi_ff[AXIS_X];
      ye_lo = (lo_ff[AXIS_Y] < B_Y_MIN) ? B_Y_MIN : lo_ff[AXIS_Y];
      ye_hi = (hi_ff[AXIS_Y] > B_Y_MAX) ? B_Y_MAX : hi_ff[AXIS_Y];
      ze_lo = (lo_ff[AXIS_Z] < B_ZERO)  ? B_ZERO  : lo_ff[AXIS_Z];
      ze_hi = (hi_ff[AXIS_Z] > B_Z_MAX) ? B_Z_MAX : hi_ff[AXIS_Z];
      cx_b  = BND_W'(cell_x_ff);
      cy_b  = BND_W'(cell_y_ff);
      cz_b  = BND_W'(cell_z_ff);
   end

   assign rd_solid  = (rd_data_ff != '0) && (rd_data_ff != still_ff) &&
                      (rd_data_ff != flow_ff);
   assign scan_last = (zs_ff == zhi_c_ff) && (xs_ff == xhi_c_ff) && (ys_ff == ylo_c_ff);
   assign in_grid   = (32'(cell_x_ff) < 32'(vbce_pkg::GRID_X)) &&
                      (32'(cell_z_ff) < 32'(vbce_pkg::GRID_Z)) &&
                      (32'(cell_y_ff) <= 32'(vbce_pkg::HIGH_Y));

   // ground height and on-ground flag
   always_comb begin
      if (found_ff) begin
         g_val = G_W'((G_W'(hit_y_ff) + G_W'(1)) << vbce_pkg::FRAC_BITS);
      end else begin
         g_val = G_NONE;
      end
      diff  = DF_W'(pos_ff[AXIS_Y]) - DF_W'(g_val);
      tol_s = DF_W'(tol_ff);
      g_on  = (diff <= tol_s) && (diff >= -tol_s);
      if (g_val > G_MAX) begin
         g_sat = C_MAX;
      end else if (g_val < G_MIN) begin
         g_sat = C_MIN;
      end else begin
         g_sat = COORD_W'(g_val);
      end
   end

   // store ports
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_addr_ff;
      mem_wdata = '0;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == S_WRITE) begin
         mem_we    = in_grid;
         mem_waddr = vbce_pkg::cell_addr(XW'(cell_x_ff), YW'(cell_y_ff), ZW'(cell_z_ff));
         mem_wdata = cell_id_ff;
      end
      mem_raddr = vbce_pkg::cell_addr(xs_ff, ys_ff, zs_ff);
   end

   // configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      still_in  = still_ff;
      flow_in   = flow_ff;
      tol_in    = tol_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            vbce_pkg::CSR_PLAYER_WIDTH:  width_in  = csr_bus.wdata;
            vbce_pkg::CSR_PLAYER_HEIGHT: height_in = csr_bus.wdata;
            vbce_pkg::CSR_STILL_WATER:   still_in  = vbce_pkg::ID_W'(csr_bus.wdata);
            vbce_pkg::CSR_FLOW_WATER:    flow_in   = vbce_pkg::ID_W'(csr_bus.wdata);
            vbce_pkg::CSR_GROUND_TOL:    tol_in    = vbce_pkg::TOL_W'(csr_bus.wdata);
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      clr_addr_in   = clr_addr_ff;
      issue_done_in = issue_done_ff;
      rd_valid_in   = 1'b0;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      move_in       = move_ff;
      cell_x_in     = cell_x_ff;
      cell_y_in     = cell_y_ff;
      cell_z_in     = cell_z_ff;
      cell_id_in    = cell_id_ff;
      t_in          = t_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      xlo_c_in      = xlo_c_ff;
      xhi_c_in      = xhi_c_ff;
      zlo_c_in      = zlo_c_ff;
      zhi_c_in      = zhi_c_ff;
      ylo_c_in      = ylo_c_ff;
      xs_in         = xs_ff;
      ys_in         = ys_ff;
      zs_in         = zs_ff;
      rd_y_in       = rd_y_ff;
      hit_y_in      = hit_y_ff;
      rsp_collides_in  = rsp_collides_ff;
      rsp_height_in    = rsp_height_ff;
      rsp_on_ground_in = rsp_on_ground_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(vbce_pkg::STORE_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               mode_in         = req_bus.mode;
               pos_in[AXIS_X]  = req_bus.pos_x;
               pos_in[AXIS_Y]  = req_bus.pos_y;
               pos_in[AXIS_Z]  = req_bus.pos_z;
               move_in[AXIS_X] = req_bus.move_x;
               move_in[AXIS_Y] = req_bus.move_y;
               move_in[AXIS_Z] = req_bus.move_z;
               cell_x_in       = req_bus.cell_x;
               cell_y_in       = req_bus.cell_y;
               cell_z_in       = req_bus.cell_z;
               cell_id_in      = req_bus.cell_id;
               found_in        = 1'b0;
               axis_in         = AXIS_X;
               state_in        = (req_bus.mode == vbce_pkg::MODE_WRITE) ? S_WRITE : S_TGT;
            end
         end
         S_WRITE: begin
            state_in = S_FIN;
         end
         S_TGT: begin
            t_in[axis_ff] = t_sat;
            if (axis_ff == AXIS_Z) begin
               axis_in  = AXIS_X;
               state_in = S_BND;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         S_BND: begin
            if (axis_ff == AXIS_Y && mode_ff == vbce_pkg::MODE_GROUND) begin
               // ground search: layers from floor(y)-1 downward
               lo_in[axis_ff] = start_b - B_SCAN;
               hi_in[axis_ff] = start_b;
            end else begin
               lo_in[axis_ff] = lo_b;
               hi_in[axis_ff] = hi_b;
            end
            if (axis_ff == AXIS_Z) begin
               axis_in  = AXIS_X;
               state_in = S_INIT;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         S_INIT: begin
            xlo_c_in      = XW'(xe_lo);
            xhi_c_in      = XW'(xe_hi);
            zlo_c_in      = ZW'(ze_lo);
            zhi_c_in      = ZW'(ze_hi);
            ylo_c_in      = YW'(ye_lo);
            xs_in         = XW'(xe_lo);
            zs_in         = ZW'(ze_lo);
            ys_in         = YW'(ye_hi);
            issue_done_in = 1'b0;
            if (mode_ff == vbce_pkg::MODE_CELL) begin
               found_in = (cx_b >= lo_ff[AXIS_X]) && (cx_b <= hi_ff[AXIS_X]) &&
                          (cy_b >= lo_ff[AXIS_Y]) && (cy_b <= hi_ff[AXIS_Y]) &&
                          (cz_b >= lo_ff[AXIS_Z]) && (cz_b <= hi_ff[AXIS_Z]);
               state_in = S_FIN;
            end else if ((xe_lo > xe_hi) || (ye_lo > ye_hi) || (ze_lo > ze_hi)) begin
               state_in = S_FIN;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // read one cell a cycle, check it the next; stop at the first solid
            if (rd_valid_ff && rd_solid) begin
               found_in = 1'b1;
               hit_y_in = rd_y_ff;
               state_in = S_FIN;
            end else if (issue_done_ff) begin
               state_in = S_FIN;
            end else begin
               rd_valid_in   = 1'b1;
               rd_y_in       = ys_ff;
               issue_done_in = scan_last;
               if (!scan_last) begin
                  if (zs_ff != zhi_c_ff) begin
                     zs_in = zs_ff + ZW'(1);
                  end else begin
                     zs_in = zlo_c_ff;
                     if (xs_ff != xhi_c_ff) begin
                        xs_in = xs_ff + XW'(1);
                     end else begin
                        xs_in = xlo_c_ff;
                        ys_in = ys_ff - YW'(1);
                     end
                  end
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_collides_in  = found_ff && ((mode_ff == vbce_pkg::MODE_COLLIDE) ||
                                               (mode_ff == vbce_pkg::MODE_CELL));
               rsp_height_in    = (mode_ff == vbce_pkg::MODE_GROUND) ? g_sat : '0;
               rsp_on_ground_in = (mode_ff == vbce_pkg::MODE_GROUND) && g_on;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         axis_ff       <= AXIS_X;
         clr_addr_ff   <= '0;
         issue_done_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         width_ff      <= vbce_pkg::RST_PLAYER_WIDTH;
         height_ff     <= vbce_pkg::RST_PLAYER_HEIGHT;
         still_ff      <= vbce_pkg::RST_STILL_WATER;
         flow_ff       <= vbce_pkg::RST_FLOW_WATER;
         tol_ff        <= vbce_pkg::RST_GROUND_TOL;
      end else begin
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         clr_addr_ff   <= clr_addr_in;
         issue_done_ff <= issue_done_in;
         rd_valid_ff   <= rd_valid_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         still_ff      <= still_in;
         flow_ff       <= flow_in;
         tol_ff        <= tol_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff          <= mode_in;
      pos_ff           <= pos_in;
      move_ff          <= move_in;
      cell_x_ff        <= cell_x_in;
      cell_y_ff        <= cell_y_in;
      cell_z_ff        <= cell_z_in;
      cell_id_ff       <= cell_id_in;
      t_ff             <= t_in;
      lo_ff            <= lo_in;
      hi_ff            <= hi_in;
      xlo_c_ff         <= xlo_c_in;
      xhi_c_ff         <= xhi_c_in;
      zlo_c_ff         <= zlo_c_in;
      zhi_c_ff         <= zhi_c_in;
      ylo_c_ff         <= ylo_c_in;
      xs_ff            <= xs_in;
      ys_ff            <= ys_in;
      zs_ff            <= zs_in;
      rd_y_ff          <= rd_y_in;
      hit_y_ff         <= hit_y_in;
      rsp_collides_ff  <= rsp_collides_in;
      rsp_height_ff    <= rsp_height_in;
      rsp_on_ground_ff <= rsp_on_ground_in;
   end

   // voxel store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[mem_raddr];
   end

   a_scan_xz_in_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> xs_ff >= xlo_c_ff && xs_ff <= xhi_c_ff &&
                             zs_ff >= zlo_c_ff && zs_ff <= zhi_c_ff)
      else $error("scan counter left the clamped footprint");

   a_scan_y_in_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> ys_ff >= ylo_c_ff)
      else $error("scan layer went below the lowest layer");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIN)
      else $error("response raised outside the finish step");

   a_read_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> state_ff == S_SCAN || state_ff == S_FIN)
      else $error("store read pending outside a scan");

endmodule

// ===== tb/sv/vbce_answer_checker.sv =====
// ----------------------------------------------------------------------------
// vbce_answer_checker: response checker of the voxel box collision engine
// Watches the request, response and register channels, keeps its own copy of
// the voxel grid and the box registers, works out the answer to each request
// and compares every response field with the oldest outstanding answer.
// ----------------------------------------------------------------------------
module vbce_answer_checker
   import vbce_pkg::*;
(
   input  logic clock,
   input  logic reset,
   vbce_req_if  req_bus,
   vbce_rsp_if  rsp_bus,
   vbce_csr_if  csr_bus,
   output int   fail_count,
   output int   awaited
);

   typedef struct packed {
      logic                      collides;
      logic signed [COORD_W-1:0] ground_height;
      logic                      on_ground;
   } answer_t;

   localparam longint UNIT     = longint'(1) << FRAC_BITS;
   localparam longint SPAN     = 2 * UNIT;                 // one cell in doubled units
   localparam int     SHIFT2   = FRAC_BITS + 1;
   localparam longint COORD_HI = (longint'(1) << (COORD_W - 1)) - 1;
   localparam longint COORD_LO = -(longint'(1) << (COORD_W - 1));

   // grid starts as air, as the block's own clearing pass leaves it
   bit   [ID_W-1:0]   grid_ids [STORE_SIZE];
   logic [SIZE_W-1:0] box_w;
   logic [SIZE_W-1:0] box_h;
   logic [ID_W-1:0]   still_id;
   logic [ID_W-1:0]   flow_id;
   logic [TOL_W-1:0]  tol;
   answer_t           answers_due [$];

   function automatic longint sat_coord(input longint v);
      if (v > COORD_HI) return COORD_HI;
      if (v < COORD_LO) return COORD_LO;
      return v;
   endfunction

   function automatic longint clampl(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic bit is_solid(input longint x, input longint y, input longint z);
      longint        a;
      logic [ID_W-1:0] id;
      if (x < 0 || x >= GRID_X || z < 0 || z >= GRID_Z || y < LOW_Y || y > HIGH_Y)
         return 1'b0;
      a  = ((y - LOW_Y) * GRID_Z + z) * GRID_X + x;
      id = grid_ids[a];
      return id != '0 && id != still_id && id != flow_id;
   endfunction

   // strict overlap of a doubled-unit interval with unit cell c
   function automatic bit spans(input longint lo2, input longint hi2, input longint c);
      return hi2 > c * SPAN && lo2 < (c + 1) * SPAN;
   endfunction

   function automatic answer_t box_answer(
      input logic [MODE_W-1:0]         mode,
      input logic signed [COORD_W-1:0] px, py, pz, mx, my, mz,
      input logic [CELL_W-1:0]         cx, cy, cz);
      longint  w, h, tx, ty, tz, xl, xh, yl, yh, zl, zh;
      longint  x0, x1, y0, y1, z0, z1, x, y, z, start, g, diff;
      bit      hit;
      answer_t a;
      a   = '0;
      hit = 1'b0;
      w   = longint'(box_w);
      h   = longint'(box_h);
      case (mode)
         MODE_COLLIDE: begin
            tx = sat_coord(longint'(px) + longint'(mx));
            ty = sat_coord(longint'(py) + longint'(my));
            tz = sat_coord(longint'(pz) + longint'(mz));
            xl = 2 * tx - w;  xh = 2 * tx + w;
            yl = 2 * ty;      yh = 2 * ty + 2 * h;
            zl = 2 * tz - w;  zh = 2 * tz + w;
            x0 = clampl(xl >>> SHIFT2, 0, GRID_X);
            x1 = clampl(xh >>> SHIFT2, -1, GRID_X - 1);
            y0 = clampl(yl >>> SHIFT2, LOW_Y, HIGH_Y + 1);
            y1 = clampl(yh >>> SHIFT2, LOW_Y - 1, HIGH_Y);
            z0 = clampl(zl >>> SHIFT2, 0, GRID_Z);
            z1 = clampl(zh >>> SHIFT2, -1, GRID_Z - 1);
            for (x = x0; x <= x1; x++)
               for (y = y0; y <= y1; y++)
                  for (z = z0; z <= z1; z++)
                     if (!hit && is_solid(x, y, z) && spans(xl, xh, x) &&
                         spans(yl, yh, y) && spans(zl, zh, z))
                        hit = 1'b1;
            a.collides = hit;
         end
         MODE_GROUND: begin
            x0    = clampl((2 * longint'(px) - w) >>> SHIFT2, 0, GRID_X);
            x1    = clampl((2 * longint'(px) + w) >>> SHIFT2, -1, GRID_X - 1);
            z0    = clampl((2 * longint'(pz) - w) >>> SHIFT2, 0, GRID_Z);
            z1    = clampl((2 * longint'(pz) + w) >>> SHIFT2, -1, GRID_Z - 1);
            start = (longint'(py) >>> FRAC_BITS) - 1;
            g     = longint'(LOW_Y - 100) * UNIT;
            for (y = start; y >= LOW_Y && y > start - GROUND_SCAN && !hit; y--)
               for (x = x0; x <= x1; x++)
                  for (z = z0; z <= z1; z++)
                     if (!hit && is_solid(x, y, z)) begin
                        hit = 1'b1;
                        g   = (y + 1) * UNIT;
                     end
            // on-ground uses the exact height, the output the saturated one
            diff = longint'(py) - g;
            if (diff < 0) diff = -diff;
            a.on_ground     = diff <= longint'(tol);
            a.ground_height = COORD_W'(sat_coord(g));
         end
         MODE_CELL: begin
            xl = 2 * longint'(px) - w;  xh = 2 * longint'(px) + w;
            yl = 2 * longint'(py);      yh = 2 * longint'(py) + 2 * h;
            zl = 2 * longint'(pz) - w;  zh = 2 * longint'(pz) + w;
            a.collides = spans(xl, xh, longint'(cx)) && spans(yl, yh, longint'(cy)) &&
                         spans(zl, zh, longint'(cz));
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_t want;
      if (reset) begin
         box_w      = RST_PLAYER_WIDTH;
         box_h      = RST_PLAYER_HEIGHT;
         still_id   = RST_STILL_WATER;
         flow_id    = RST_FLOW_WATER;
         tol        = RST_GROUND_TOL;
         fail_count = 0;
         answers_due.delete();
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (answers_due.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_bus.collides !== want.collides) begin
                  $error("collides: expected %0b, got %0b", want.collides, rsp_bus.collides);
                  fail_count++;
               end
               if (rsp_bus.ground_height !== want.ground_height) begin
                  $error("ground_height: expected %0d, got %0d",
                         $signed(want.ground_height), $signed(rsp_bus.ground_height));
                  fail_count++;
               end
               if (rsp_bus.on_ground !== want.on_ground) begin
                  $error("on_ground: expected %0b, got %0b", want.on_ground, rsp_bus.on_ground);
                  fail_count++;
               end
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            answers_due.push_back(box_answer(req_bus.mode, req_bus.pos_x, req_bus.pos_y,
                                             req_bus.pos_z, req_bus.move_x, req_bus.move_y,
                                             req_bus.move_z, req_bus.cell_x, req_bus.cell_y,
                                             req_bus.cell_z));
            if (req_bus.mode == MODE_WRITE)
               grid_ids[((int'(req_bus.cell_y) - LOW_Y) * GRID_Z + int'(req_bus.cell_z))
                        * GRID_X + int'(req_bus.cell_x)] = req_bus.cell_id;
         end
         if (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1) begin
            case (csr_bus.index)
               CSR_PLAYER_WIDTH:  box_w    = csr_bus.wdata[SIZE_W-1:0];
               CSR_PLAYER_HEIGHT: box_h    = csr_bus.wdata[SIZE_W-1:0];
               CSR_STILL_WATER:   still_id = csr_bus.wdata[ID_W-1:0];
               CSR_FLOW_WATER:    flow_id  = csr_bus.wdata[ID_W-1:0];
               CSR_GROUND_TOL:    tol      = csr_bus.wdata[TOL_W-1:0];
               default: ;
            endcase
         end
      end
      awaited <= answers_due.size();
   end

endmodule

// ===== tb/sv/voxel_box_collision_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// voxel_box_collision_engine_unit_tb: top of the collision engine testbench
// Directed requests on grid edges, water, face contact and saturation, then
// random requests clustered round two corners of the grid under several box
// settings, with random idling, a long response hold-off and a gap-free
// phase. The answer checker does the comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module voxel_box_collision_engine_unit_tb;
   import vbce_pkg::*;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [COORD_W-1:0] px, py, pz, mx, my, mz;
      logic [CELL_W-1:0]  cx, cy, cz;
      logic [ID_W-1:0]    id;
   } query_t;

   localparam int UNIT     = 1 << FRAC_BITS;
   localparam int PER_RUN  = 65;       // random requests per box setting
   localparam int HOLD_OFF = 400;      // cycles the receiver holds off

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   gaps_on = 1'b1;
   bit   rsp_hold = 1'b0;
   int   fail_count;
   int   awaited;
   logic [ID_W-1:0] cur_still = RST_STILL_WATER;
   logic [ID_W-1:0] cur_flow  = RST_FLOW_WATER;

   vbce_req_if req_bus ();
   vbce_rsp_if rsp_bus ();
   vbce_csr_if csr_bus ();

   voxel_box_collision_engine_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   vbce_answer_checker i_answer_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .fail_count (fail_count),
      .awaited    (awaited)
   );

   always #6 clock = ~clock;

   function automatic query_t q_write(input int x, input int y, input int z, input int id);
      query_t q;
      q      = '0;
      q.mode = MODE_WRITE;
      q.cx   = CELL_W'(x);
      q.cy   = CELL_W'(y);
      q.cz   = CELL_W'(z);
      q.id   = ID_W'(id);
      return q;
   endfunction

   function automatic query_t q_collide(input int px, input int py, input int pz,
                                        input int mx, input int my, input int mz);
      query_t q;
      q      = '0;
      q.mode = MODE_COLLIDE;
      q.px   = COORD_W'(px);
      q.py   = COORD_W'(py);
      q.pz   = COORD_W'(pz);
      q.mx   = COORD_W'(mx);
      q.my   = COORD_W'(my);
      q.mz   = COORD_W'(mz);
      return q;
   endfunction

   function automatic query_t q_ground(input int px, input int py, input int pz);
      query_t q;
      q      = '0;
      q.mode = MODE_GROUND;
      q.px   = COORD_W'(px);
      q.py   = COORD_W'(py);
      q.pz   = COORD_W'(pz);
      return q;
   endfunction

   function automatic query_t q_overlap(input int px, input int py, input int pz,
                                        input int cx, input int cy, input int cz);
      query_t q;
      q      = '0;
      q.mode = MODE_CELL;
      q.px   = COORD_W'(px);
      q.py   = COORD_W'(py);
      q.pz   = COORD_W'(pz);
      q.cx   = CELL_W'(cx);
      q.cy   = CELL_W'(cy);
      q.cz   = CELL_W'(cz);
      return q;
   endfunction

   // position within a couple of blocks of an eight-cell corner zone
   function automatic logic [COORD_W-1:0] coord_near(input int base);
      int off;
      int frac;
      off  = $urandom_range(0, 11);
      frac = $urandom_range(0, UNIT - 1);
      return COORD_W'((base + off - 2) * UNIT + frac);
   endfunction

   function automatic logic [COORD_W-1:0] small_move();
      int m;
      m = $urandom_range(0, 2 * UNIT - 1);
      return COORD_W'(m - UNIT);
   endfunction

   function automatic query_t random_query();
      query_t q;
      int     base;
      int     pick;
      int     off;
      q = {$urandom, $urandom, $urandom, $urandom};
      // a slice of pure noise; unused fields stay random on the rest
      if ($urandom_range(99) < 8) return q;
      base = $urandom_range(1) ? 0 : GRID_X - 8;
      pick = $urandom_range(99);
      if (pick < 35) begin
         q.mode = MODE_WRITE;
         q.cx   = CELL_W'(base + $urandom_range(7));
         q.cy   = CELL_W'(base + $urandom_range(7));
         q.cz   = CELL_W'(base + $urandom_range(7));
         pick   = $urandom_range(99);
         q.id   = (pick < 20) ? '0 : (pick < 30) ? cur_still : (pick < 40) ? cur_flow :
                  ID_W'($urandom_range(1, 255));
      end else if (pick < 60) begin
         q.mode = MODE_COLLIDE;
         q.px   = coord_near(base);
         q.py   = coord_near(base);
         q.pz   = coord_near(base);
         if ($urandom_range(99) < 80) begin
            q.mx = small_move();
            q.my = small_move();
            q.mz = small_move();
         end
      end else if (pick < 85) begin
         q.mode = MODE_GROUND;
         q.px   = coord_near(base);
         q.py   = coord_near(base);
         q.pz   = coord_near(base);
      end else begin
         q.mode = MODE_CELL;
         q.cx   = CELL_W'(base + $urandom_range(7));
         q.cy   = CELL_W'(base + $urandom_range(7));
         q.cz   = CELL_W'(base + $urandom_range(7));
         off    = $urandom_range(0, 3 * UNIT - 1);
         q.px   = COORD_W'(int'(q.cx) * UNIT + off - UNIT);
         off    = $urandom_range(0, 3 * UNIT - 1);
         q.py   = COORD_W'(int'(q.cy) * UNIT + off - 2 * UNIT);
         off    = $urandom_range(0, 3 * UNIT - 1);
         q.pz   = COORD_W'(int'(q.cz) * UNIT + off - UNIT);
      end
      return q;
   endfunction

   task automatic offer(input query_t q);
      while (gaps_on && $urandom_range(99) < 13) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= q.mode;
      req_bus.pos_x   <= q.px;
      req_bus.pos_y   <= q.py;
      req_bus.pos_z   <= q.pz;
      req_bus.move_x  <= q.mx;
      req_bus.move_y  <= q.my;
      req_bus.move_z  <= q.mz;
      req_bus.cell_x  <= q.cx;
      req_bus.cell_y  <= q.cy;
      req_bus.cell_z  <= q.cz;
      req_bus.cell_id <= q.id;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // stop offering and wait for every outstanding answer
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (awaited != 0);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= CSR_DATA_W'(val);
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
   endtask

   task automatic apply_setting(input int w, input int h, input int still, input int flow,
                                input int tol);
      csr_put(CSR_PLAYER_WIDTH, w);
      csr_put(CSR_PLAYER_HEIGHT, h);
      csr_put(CSR_STILL_WATER, still);
      csr_put(CSR_FLOW_WATER, flow);
      csr_put(CSR_GROUND_TOL, tol);
      csr_bus.valid <= 1'b0;
      cur_still = ID_W'(still);
      cur_flow  = ID_W'(flow);
   endtask

   // response side: random back-pressure, or one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            rsp_hold = 1'b0;
         end else begin
            rsp_bus.ready <= !(gaps_on && $urandom_range(99) < 13);
         end
      end
   end

   initial begin
      int run;
      int n;
      req_bus.valid   <= 1'b0;
      req_bus.mode    <= MODE_WRITE;
      req_bus.pos_x   <= '0;
      req_bus.pos_y   <= '0;
      req_bus.pos_z   <= '0;
      req_bus.move_x  <= '0;
      req_bus.move_y  <= '0;
      req_bus.move_z  <= '0;
      req_bus.cell_x  <= '0;
      req_bus.cell_y  <= '0;
      req_bus.cell_z  <= '0;
      req_bus.cell_id <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= CSR_PLAYER_WIDTH;
      csr_bus.wdata   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset box: 154 wide, 461 tall
      offer(q_write(0, 0, 0, 1));
      offer(q_write(63, 63, 63, 255));
      offer(q_write(1, 0, 0, cur_still));
      offer(q_write(2, 0, 0, cur_flow));
      offer(q_write(4, 0, 0, 0));
      offer(q_collide(128, 0, 128, 0, 0, 0));
      offer(q_collide(384, 0, 128, 0, 0, 0));
      // box face exactly on the x boundary of the solid cell
      offer(q_collide(0, 0, 0, 333, 0, 128));
      offer(q_collide(32767, 32767, 32767, 32767, 32767, 32767));
      offer(q_collide(-32768, -32768, -32768, -32768, -32768, -32768));
      offer(q_collide(16256, 16128, 16256, 0, 0, 0));
      offer(q_collide(16256, 16384, 16256, 0, 0, 0));
      offer(q_ground(128, UNIT, 128));
      offer(q_ground(128, UNIT + 2, 128));
      offer(q_ground(128, UNIT + 3, 128));
      offer(q_ground(-64, UNIT, 128));
      offer(q_ground(20 * UNIT, 0, 20 * UNIT));
      offer(q_ground(20 * UNIT, (LOW_Y - 100) * UNIT, 20 * UNIT));
      offer(q_ground(16256, 64 * UNIT, 16256));
      offer(q_ground(0, 32767, 0));
      offer(q_overlap(896, 4 * UNIT, 1408, 3, 4, 5));
      offer(q_overlap(3 * UNIT - 77, 4 * UNIT, 1408, 3, 4, 5));
      offer(q_overlap(-32768, -32768, -32768, 0, 0, 0));
      offer(q_overlap(32767, 32767, 32767, 63, 63, 63));
      drain();

      for (run = 0; run < 6; run++) begin
         case (run)
            0: apply_setting(512, 768, 0, 255, 255);
            1: apply_setting(0, 0, 255, 0, 0);
            2: apply_setting($urandom_range(0, 512), $urandom_range(0, 768),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
            3: begin
               apply_setting(RST_PLAYER_WIDTH, RST_PLAYER_HEIGHT, RST_STILL_WATER,
                             RST_FLOW_WATER, RST_GROUND_TOL);
               gaps_on = 1'b0;
            end
            4: begin
               gaps_on = 1'b1;
               apply_setting($urandom_range(64, 512), $urandom_range(128, 768),
                             $urandom_range(1, 255), $urandom_range(1, 255),
                             $urandom_range(0, 255));
               // block fills and stalls its input while responses are held
               rsp_hold = 1'b1;
            end
            default: apply_setting($urandom_range(0, 512), $urandom_range(0, 768),
                                   $urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255));
         endcase
         for (n = 0; n < PER_RUN; n++)
            offer(random_query());
         drain();
      end

      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // the clearing pass alone writes all 262144 cells
   initial begin
      #36_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
sv/vbce_pkg.sv
sv/vbce_if.sv
sv/voxel_box_collision_engine_unit.sv
tb/sv/vbce_answer_checker.sv
tb/sv/voxel_box_collision_engine_unit_tb.sv
